FILE: rtl/core/pn3d_pkg.sv
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared types and constants of the 3D gradient noise unit.
// ----------------------------------------------------------------------------
package pn3d_pkg;

    localparam int COORD_W = 24;
    localparam int OUT_W   = 18;
    localparam int IDX_W   = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    table_index;
        logic [IDX_W-1:0]    table_value;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [COORD_W-1:0]  coord_z;
    } req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] noise_value;
    } rsp_t;

endpackage

FILE: rtl/core/pn3d_if.sv
// ----------------------------------------------------------------------------
// pn3d_req_if / pn3d_rsp_if
// Valid/ready channels of the noise unit.
// ----------------------------------------------------------------------------
interface pn3d_req_if;
    logic            valid;
    logic            ready;
    pn3d_pkg::req_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pn3d_rsp_if;
    logic            valid;
    logic            ready;
    pn3d_pkg::rsp_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/perlin_noise_3d_unit.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_unit
// Improved 3D gradient noise, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters every cycle while the output stage is free or being taken.
// Depth is set by the three dependent permutation lookups, each a
// registered read of the 256-entry table (one copy for the first level, two
// for the second, four for the third, each read at two addresses), and the
// fade and blend multiplies. A load item reaches each level's copies when it
// passes that level, so it never changes lookups of items ahead of it, and it
// gives no result. The whole pipe advances only when the output stage is free
// or being taken, so a stall holds every stage.
module perlin_noise_3d_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pn3d_req_if.sink   req,
    pn3d_rsp_if.source rsp
);
    localparam int FB  = FRAC_BITS;
    localparam int GW  = FB + 3;   // gradient sum width (signed)
    localparam int VW  = FB + 6;   // blend value width
    localparam int NS  = 9;

    logic en;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    // stage 0 capture
    logic [7:0]    ix_reg, iy_reg, iz_reg;
    logic [FB-1:0] fx_reg [4], fy_reg [4], fz_reg [4];

    logic [7:0] perm0 [256];
    logic [7:0] perm1 [256];
    logic [7:0] perm2 [256];
    logic [7:0] perm3 [256];
    logic [7:0] perm4 [256];
    logic [7:0] perm5 [256];
    logic [7:0] perm6 [256];
    logic       wr;
    logic       wr1_reg, wr2_reg;
    logic [7:0] widx1_reg, widx2_reg, wval1_reg, wval2_reg;

    assign wr = req.valid && req.ready && req.payload.req_type == pn3d_pkg::REQ_LOAD;

    // Write each level's copies as the load passes that level.
    always_ff @(posedge clk)
    begin
        if (wr)
            perm0[req.payload.table_index] <= req.payload.table_value;
        if (en && wr1_reg)
        begin
            perm1[widx1_reg] <= wval1_reg;
            perm2[widx1_reg] <= wval1_reg;
        end
        if (en && wr2_reg)
        begin
            perm3[widx2_reg] <= wval2_reg;
            perm4[widx2_reg] <= wval2_reg;
            perm5[widx2_reg] <= wval2_reg;
            perm6[widx2_reg] <= wval2_reg;
        end
        if (en)
        begin
            widx1_reg <= req.payload.table_index;
            wval1_reg <= req.payload.table_value;
            widx2_reg <= widx1_reg;
            wval2_reg <= wval1_reg;
        end
    end

    // valid chain
    always_comb
    begin
        v_next = v_reg;
        if (en)
            v_next = {v_reg[NS-2:0], req.valid && req.payload.req_type == pn3d_pkg::REQ_EVAL};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            wr1_reg <= 1'b0;
            wr2_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
            if (en)
            begin
                wr1_reg <= wr;
                wr2_reg <= wr1_reg;
            end
        end
    end

    assign rsp.valid = v_reg[NS-1];

    // fractions travel down the pipe
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_reg    <= 8'(req.payload.coord_x >> FB);
            iy_reg    <= 8'(req.payload.coord_y >> FB);
            iz_reg    <= 8'(req.payload.coord_z >> FB);
            fx_reg[0] <= req.payload.coord_x[FB-1:0];
            fy_reg[0] <= req.payload.coord_y[FB-1:0];
            fz_reg[0] <= req.payload.coord_z[FB-1:0];
            for (int i = 1; i < 4; i++)
            begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    // lookup level 1: perm[ix], perm[ix+1]; registered reads
    logic [7:0] pa_reg, pb_reg, iy1_reg, iz1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= perm0[ix_reg];
            pb_reg  <= perm0[ix_reg + 8'd1];
            iy1_reg <= iy_reg;
            iz1_reg <= iz_reg;
        end
    end

    // level 2: a, a+1, b, b+1
    logic [7:0] a, b;
    logic [7:0] paa_reg, pab_reg, pba_reg, pbb_reg, iz2_reg;
    assign a = pa_reg + iy1_reg;
    assign b = pb_reg + iy1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            paa_reg <= perm1[a];
            pab_reg <= perm1[a + 8'd1];
            pba_reg <= perm2[b];
            pbb_reg <= perm2[b + 8'd1];
            iz2_reg <= iz1_reg;
        end
    end

    // level 3: eight corner hashes
    logic [7:0] aa, ab, ba, bb;
    logic [3:0] h_reg [8];
    assign aa = paa_reg + iz2_reg;
    assign ab = pab_reg + iz2_reg;
    assign ba = pba_reg + iz2_reg;
    assign bb = pbb_reg + iz2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg[0] <= perm3[aa][3:0];
            h_reg[1] <= perm4[ba][3:0];
            h_reg[2] <= perm5[ab][3:0];
            h_reg[3] <= perm6[bb][3:0];
            h_reg[4] <= perm3[aa + 8'd1][3:0];
            h_reg[5] <= perm4[ba + 8'd1][3:0];
            h_reg[6] <= perm5[ab + 8'd1][3:0];
            h_reg[7] <= perm6[bb + 8'd1][3:0];
        end
    end

    // fades start at stage 2 and are ready for the stage 5 blends
    logic [FB:0] fu, fv, fw;
    pn3d_fade #(.FB(FB)) u_fade_x (.clk(clk), .en(en), .t(fx_reg[1]), .fade(fu));
    pn3d_fade #(.FB(FB)) u_fade_y (.clk(clk), .en(en), .t(fy_reg[1]), .fade(fv));
    pn3d_fade #(.FB(FB)) u_fade_z (.clk(clk), .en(en), .t(fz_reg[1]), .fade(fw));

    // stage 4: gradients from hashes (fractions at fx_reg[3])
    function automatic logic signed [GW-1:0] grad_f(
        input logic [3:0] h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        grad_f = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
    logic signed [GW-1:0] g_reg [8];
    assign x0 = GW'(fx_reg[3]);
    assign y0 = GW'(fy_reg[3]);
    assign z0 = GW'(fz_reg[3]);
    assign x1 = x0 - GW'(1 << FB);
    assign y1 = y0 - GW'(1 << FB);
    assign z1 = z0 - GW'(1 << FB);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg[0] <= grad_f(h_reg[0], x0, y0, z0);
            g_reg[1] <= grad_f(h_reg[1], x1, y0, z0);
            g_reg[2] <= grad_f(h_reg[2], x0, y1, z0);
            g_reg[3] <= grad_f(h_reg[3], x1, y1, z0);
            g_reg[4] <= grad_f(h_reg[4], x0, y0, z1);
            g_reg[5] <= grad_f(h_reg[5], x1, y0, z1);
            g_reg[6] <= grad_f(h_reg[6], x0, y1, z1);
            g_reg[7] <= grad_f(h_reg[7], x1, y1, z1);
        end
    end

    // blend: a + floor(f*(b-a)/S), arithmetic shift floors
    function automatic logic signed [VW-1:0] lerp_f(
        input logic [FB:0] f,
        input logic signed [VW-1:0] lo,
        input logic signed [VW-1:0] hi
    );
        logic signed [VW+FB+2:0] p;
        p = $signed({1'b0, f}) * (hi - lo);
        lerp_f = lo + VW'(p >>> FB);
    endfunction

    // stage 5: x blends; the fade outputs hold this item's values here
    logic signed [VW-1:0] lx_reg [4];
    logic [FB:0] fv6_reg, fw6_reg, fw7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg[0] <= lerp_f(fu, VW'(g_reg[0]), VW'(g_reg[1]));
            lx_reg[1] <= lerp_f(fu, VW'(g_reg[2]), VW'(g_reg[3]));
            lx_reg[2] <= lerp_f(fu, VW'(g_reg[4]), VW'(g_reg[5]));
            lx_reg[3] <= lerp_f(fu, VW'(g_reg[6]), VW'(g_reg[7]));
            fv6_reg   <= fv;
            fw6_reg   <= fw;
            fw7_reg   <= fw6_reg;
        end
    end

    // stage 6: y blends, stage 7: z blend
    logic signed [VW-1:0] ly_reg [2];
    logic signed [VW-1:0] lz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ly_reg[0] <= lerp_f(fv6_reg, lx_reg[0], lx_reg[1]);
            ly_reg[1] <= lerp_f(fv6_reg, lx_reg[2], lx_reg[3]);
            lz_reg    <= lerp_f(fw7_reg, ly_reg[0], ly_reg[1]);
        end
    end

    // stage 8: scale to 16 fraction bits and saturate
    logic signed [VW+16:0] scaled;
    always_comb
    begin
        if (FB >= 16)
            scaled = (VW+17)'(lz_reg >>> (FB - 16));
        else
            scaled = (VW+17)'(lz_reg) <<< (16 - FB);
    end

    logic signed [pn3d_pkg::OUT_W-1:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (scaled > (VW+17)'(pn3d_pkg::OUT_MAX))
                out_reg <= pn3d_pkg::OUT_MAX;
            else if (scaled < (VW+17)'(pn3d_pkg::OUT_MIN))
                out_reg <= pn3d_pkg::OUT_MIN;
            else
                out_reg <= pn3d_pkg::OUT_W'(scaled);
        end
    end

    assign rsp.payload.noise_value = out_reg;
endmodule

FILE: rtl/core/pn3d_fade.sv
// ----------------------------------------------------------------------------
// pn3d_fade
// Pipelined quintic fade 6t^5-15t^4+10t^3, three register stages, with enable.
// ----------------------------------------------------------------------------
module pn3d_fade #(
    parameter int FB = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [FB-1:0] t,
    output logic [FB:0]   fade
);
    localparam int PW = FB + 4;

    logic [FB-1:0]   t1_reg;
    logic [PW-1:0]   c_reg;
    logic [FB-1:0]   sq_reg;
    logic [PW-1:0]   p_reg;
    logic [FB+1:0]   cube_reg;
    logic [FB:0]     fade_reg;

    logic [PW-1:0]   k_next;
    logic [2*PW-1:0] c_prod;
    logic [2*FB-1:0] sq_prod;
    logic [2*FB-1:0] cube_prod;
    logic [2*PW+1:0] r_prod;
    logic [PW+1:0]   r_sh;

    // 15S - 6t, always positive
    assign k_next    = PW'(15) * PW'(1 << FB) - PW'(6) * PW'(t);
    assign c_prod    = (2*PW)'(t) * (2*PW)'(k_next);
    assign sq_prod   = t * t;
    assign cube_prod = sq_reg * t1_reg;
    assign r_prod    = (2*PW+2)'(cube_reg) * (2*PW+2)'(p_reg);
    assign r_sh      = (PW+2)'(r_prod >> FB);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t;
            c_reg    <= PW'(c_prod >> FB);
            sq_reg   <= FB'(sq_prod >> FB);
            p_reg    <= PW'(10) * PW'(1 << FB) - c_reg;
            cube_reg <= (FB+2)'(cube_prod >> FB);
            if (r_sh > (PW+2)'(1 << FB))
                fade_reg <= (FB+1)'(1 << FB);
            else
                fade_reg <= (FB+1)'(r_sh);
        end
    end

    assign fade = fade_reg;
endmodule

FILE: rtl/core/pn3d_checker.sv
// ----------------------------------------------------------------------------
// pn3d_checker
// Port-level checks of the noise unit, bound to perlin_noise_3d_unit.
// ----------------------------------------------------------------------------
module pn3d_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic signed [17:0] noise_value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
        else $error("result dropped or changed under stall");
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("input taken while output stalled");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("not ready with empty output");
    a_reset: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result after reset");
endmodule

bind perlin_noise_3d_unit pn3d_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .noise_value(rsp.payload.noise_value)
);
